// ===== hw/rtl/isplit_pkg.sv =====
// Shared types and constants for the interval substep splitter.
package isplit_pkg;

    localparam int DATA_W       = 32;
    localparam int MAX_SUBSTEPS = 64;
    localparam int CNT_W        = $clog2(MAX_SUBSTEPS + 1);
    localparam int IDX_W        = 6;
    localparam int PROD_W       = DATA_W + CNT_W;
    localparam int NUM_W        = DATA_W + 1;
    localparam int STEP_W       = $clog2(DATA_W);

    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_FILL_W     = $clog2(Q_DEPTH + 1);

    localparam int REG_IDX_W    = 1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SUBSTEP = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_STABLE  = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_NONPOS   = 2'd1,
        ERR_ZERO_MAX = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CDIV,
        ST_MUL,
        ST_REDUCE,
        ST_BDIV,
        ST_EMIT
    } back_state_t;

    // Classified request as it waits in the queue
    typedef struct packed {
        logic [DATA_W-1:0] total;
        logic              clamped;
        err_t              err;
    } req_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

    // One substep result
    typedef struct packed {
        logic [DATA_W-1:0] substep_len;
        logic [IDX_W-1:0]  substep_index;
        logic              last;
        logic [DATA_W-1:0] total_len;
        logic              clamped_up;
        logic              split_used;
        logic              count_saturated;
        err_t              error_code;
    } res_t;

endpackage

// ===== hw/rtl/interval_substep_splitter.sv =====
// Top level of the interval substep splitter: configuration registers and the front/back split.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one requested_interval per transaction, a
//   signed tick count. Output channel (out_valid / out_stall) returns one transaction per
//   substep, with substep_index counting from zero and last marking the final one. A
//   non-positive request or a zero max_substep gives a single transaction with error_code set.
//   max_substep (index 0) and min_stable (index 1) are written through cfg_we / cfg_index /
//   cfg_wdata; the user must write them only while the block is idle, which the block itself
//   leaves unenforced. They reset to 1000 and 100 ticks.
// Operation:
//   The front end classifies a request in the cycle it is accepted and queues it; the queue
//   holds two requests. The back end works on one request at a time: fetch, saturation check,
//   ceiling division when not saturated, multiply, count reductions (0 to 63), division by
//   the count, then one substep per cycle while the output is not stalled. An error request
//   goes straight from fetch to emitting its single substep.
// Reset clears the queue, the back end state machine and the output valid. A stall on the
// output holds the current substep; the back end waits and the queue fills before the input
// is stalled.
module interval_substep_splitter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [isplit_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [isplit_pkg::DATA_W-1:0]    cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [isplit_pkg::DATA_W-1:0] requested_interval,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [isplit_pkg::DATA_W-1:0]    substep_len,
    output logic [isplit_pkg::IDX_W-1:0]     substep_index,
    output logic                             last,
    output logic [isplit_pkg::DATA_W-1:0]    total_len,
    output logic                             clamped_up,
    output logic                             split_used,
    output logic                             count_saturated,
    output logic [1:0]                       error_code
);
    import isplit_pkg::*;

    logic [DATA_W-1:0] max_substep_reg;
    logic [DATA_W-1:0] max_substep_next;
    logic [DATA_W-1:0] min_stable_reg;
    logic [DATA_W-1:0] min_stable_next;
    q_stat_t           q_stat;
    logic              push;
    req_t              push_data;
    logic              pop;
    req_t              pop_data;
    res_t              res;

    // Decode configuration writes
    always_comb
    begin
        max_substep_next = max_substep_reg;
        min_stable_next  = min_stable_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_SUBSTEP: max_substep_next = cfg_wdata;
                REG_MIN_STABLE:  min_stable_next  = cfg_wdata;
                default:         max_substep_next = max_substep_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_substep_reg <= DATA_W'(1000);
            min_stable_reg  <= DATA_W'(100);
        end
        else
        begin
            max_substep_reg <= max_substep_next;
            min_stable_reg  <= min_stable_next;
        end
    end

    isplit_front u_front (
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .requested_interval (requested_interval),
        .max_substep        (max_substep_reg),
        .min_stable         (min_stable_reg),
        .q_stat             (q_stat),
        .push               (push),
        .push_data          (push_data)
    );

    isplit_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    isplit_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_substep (max_substep_reg),
        .min_stable  (min_stable_reg),
        .q_stat      (q_stat),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .res         (res)
    );

    // Break the result out onto the payload ports
    assign substep_len     = res.substep_len;
    assign substep_index   = res.substep_index;
    assign last            = res.last;
    assign total_len       = res.total_len;
    assign clamped_up      = res.clamped_up;
    assign split_used      = res.split_used;
    assign count_saturated = res.count_saturated;
    assign error_code      = res.error_code;

endmodule

// ===== hw/rtl/isplit_front.sv =====
// Front end: accepts requests, checks for errors and clamps to the minimum stable length.
module isplit_front (
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [isplit_pkg::DATA_W-1:0] requested_interval,
    input  logic [isplit_pkg::DATA_W-1:0]   max_substep,
    input  logic [isplit_pkg::DATA_W-1:0]   min_stable,
    input  isplit_pkg::q_stat_t             q_stat,
    output logic                            push,
    output isplit_pkg::req_t                push_data
);
    import isplit_pkg::*;

    logic [DATA_W-1:0] raw;
    logic              nonpos;
    logic              below_min;

    assign raw       = DATA_W'(unsigned'(requested_interval));
    assign nonpos    = (raw == '0) || raw[DATA_W-1];
    assign below_min = min_stable > raw;

    // Classify the request; error transactions carry a zero total
    always_comb
    begin
        push_data = '0;
        if (nonpos)
        begin
            push_data.err = ERR_NONPOS;
        end
        else if (max_substep == '0)
        begin
            push_data.err = ERR_ZERO_MAX;
        end
        else
        begin
            push_data.err     = ERR_NONE;
            push_data.clamped = below_min;
            push_data.total   = below_min ? min_stable : raw;
        end
    end

    // Hold off the sender while the queue is full
    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

endmodule

// ===== hw/rtl/isplit_queue.sv =====
// Short queue of classified requests between the front and back ends.
module isplit_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  isplit_pkg::req_t   push_data,
    input  logic               pop,
    output isplit_pkg::req_t   pop_data,
    output isplit_pkg::q_stat_t q_stat
);
    import isplit_pkg::*;

    req_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_next;
    logic [Q_FILL_W-1:0] fill_reg;
    logic [Q_FILL_W-1:0] fill_next;
    logic                do_push;
    logic                do_pop;

    assign q_stat.full      = (fill_reg == Q_FILL_W'(Q_DEPTH));
    assign q_stat.not_empty = (fill_reg != '0);
    assign do_push          = push && !q_stat.full;
    assign do_pop           = pop && q_stat.not_empty;
    assign pop_data         = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + Q_FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - Q_FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/isplit_back.sv =====
// Back end: counts substeps, divides the total and emits one result per substep.
module isplit_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [isplit_pkg::DATA_W-1:0] max_substep,
    input  logic [isplit_pkg::DATA_W-1:0] min_stable,
    input  isplit_pkg::q_stat_t           q_stat,
    input  isplit_pkg::req_t              pop_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output isplit_pkg::res_t              res
);
    import isplit_pkg::*;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    res_t                res_reg;
    res_t                res_next;

    logic [DATA_W-1:0]   total_reg;
    logic [DATA_W-1:0]   total_next;
    logic                clamped_reg;
    logic                clamped_next;
    err_t                err_reg;
    err_t                err_next;
    logic                sat_reg;
    logic                sat_next;
    logic [NUM_W-1:0]    num_reg;
    logic [NUM_W-1:0]    num_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [DATA_W-1:0]   quo_reg;
    logic [DATA_W-1:0]   quo_next;
    logic [CNT_W-1:0]    brem_reg;
    logic [CNT_W-1:0]    brem_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;

    logic [PROD_W-1:0]   div_shift;
    logic [PROD_W-1:0]   num_ext;
    logic                cdiv_ge;
    logic [PROD_W-1:0]   sat_lim;
    logic                is_sat;
    logic [NUM_W-1:0]    num_init;
    logic [PROD_W-1:0]   prod_mul;
    logic                reduce_go;
    logic [CNT_W:0]      bpart;
    logic                bge;
    logic [CNT_W:0]      bdiff;
    logic                last_now;
    logic                out_load;
    logic                step_zero;

    // Datapath helpers
    assign div_shift = PROD_W'(max_substep) << step_reg;
    assign num_ext   = PROD_W'(num_reg);
    assign cdiv_ge   = num_ext >= div_shift;
    assign sat_lim   = PROD_W'(max_substep) * PROD_W'(MAX_SUBSTEPS);
    assign is_sat    = PROD_W'(total_reg) > sat_lim;
    assign num_init  = NUM_W'(total_reg) + NUM_W'(max_substep) - NUM_W'(1);
    assign prod_mul  = PROD_W'(min_stable) * PROD_W'(cnt_reg);
    assign reduce_go = (cnt_reg > CNT_W'(1)) && (PROD_W'(total_reg) < prod_reg);
    assign bpart     = {brem_reg, quo_reg[DATA_W-1]};
    assign bge       = bpart >= {1'b0, cnt_reg};
    assign bdiff     = bpart - {1'b0, cnt_reg};
    assign last_now  = (CNT_W'(idx_reg) == cnt_reg - CNT_W'(1));
    assign out_load  = !out_valid_reg || !out_stall;
    assign step_zero = (step_reg == '0);

    assign pop       = (state_reg == ST_IDLE) && q_stat.not_empty;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.not_empty)
                begin
                    state_next = (pop_data.err != ERR_NONE) ? ST_EMIT : ST_CHECK;
                end
            end
            ST_CHECK:  state_next = is_sat ? ST_MUL : ST_CDIV;
            ST_CDIV:   state_next = step_zero ? ST_MUL : ST_CDIV;
            ST_MUL:    state_next = ST_REDUCE;
            ST_REDUCE: state_next = reduce_go ? ST_REDUCE : ST_BDIV;
            ST_BDIV:   state_next = step_zero ? ST_EMIT : ST_BDIV;
            ST_EMIT:
            begin
                if (out_load && last_now)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and result register
    always_comb
    begin
        total_next     = total_reg;
        clamped_next   = clamped_reg;
        err_next       = err_reg;
        sat_next       = sat_reg;
        num_next       = num_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        quo_next       = quo_reg;
        brem_next      = brem_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Latch the next transaction; error transactions emit one empty substep
                if (q_stat.not_empty)
                begin
                    total_next   = pop_data.total;
                    clamped_next = pop_data.clamped;
                    err_next     = pop_data.err;
                    sat_next     = 1'b0;
                    cnt_next     = CNT_W'(1);
                    quo_next     = '0;
                    brem_next    = '0;
                    idx_next     = '0;
                end
            end
            ST_CHECK:
            begin
                // Saturate or start the ceiling division
                if (is_sat)
                begin
                    cnt_next = CNT_W'(MAX_SUBSTEPS);
                    sat_next = 1'b1;
                end
                else
                begin
                    num_next  = num_init;
                    cnt_next  = '0;
                    step_next = STEP_W'(CNT_W - 1);
                end
            end
            ST_CDIV:
            begin
                // One quotient bit per cycle, most significant first
                if (cdiv_ge)
                begin
                    num_next = NUM_W'(num_ext - div_shift);
                end
                cnt_next  = {cnt_reg[CNT_W-2:0], cdiv_ge};
                step_next = step_reg - STEP_W'(1);
            end
            ST_MUL:
            begin
                prod_next = prod_mul;
            end
            ST_REDUCE:
            begin
                // Drop the count while substeps would be shorter than the minimum
                if (reduce_go)
                begin
                    cnt_next  = cnt_reg - CNT_W'(1);
                    prod_next = prod_reg - PROD_W'(min_stable);
                end
                else
                begin
                    quo_next  = total_reg;
                    brem_next = '0;
                    step_next = STEP_W'(DATA_W - 1);
                end
            end
            ST_BDIV:
            begin
                // Restoring division of the total by the count
                brem_next = bge ? bdiff[CNT_W-1:0] : bpart[CNT_W-1:0];
                quo_next  = {quo_reg[DATA_W-2:0], bge};
                step_next = step_reg - STEP_W'(1);
            end
            ST_EMIT:
            begin
                // Load one substep whenever the output register frees up
                if (out_load)
                begin
                    res_next.substep_len     = last_now ? quo_reg + DATA_W'(brem_reg) : quo_reg;
                    res_next.substep_index   = idx_reg;
                    res_next.last            = last_now;
                    res_next.total_len       = total_reg;
                    res_next.clamped_up      = clamped_reg;
                    res_next.split_used      = cnt_reg > CNT_W'(1);
                    res_next.count_saturated = sat_reg;
                    res_next.error_code      = err_reg;
                    out_valid_next           = 1'b1;
                    idx_next                 = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg   <= total_next;
        clamped_reg <= clamped_next;
        err_reg     <= err_next;
        sat_reg     <= sat_next;
        num_reg     <= num_next;
        cnt_reg     <= cnt_next;
        prod_reg    <= prod_next;
        quo_reg     <= quo_next;
        brem_reg    <= brem_next;
        step_reg    <= step_next;
        idx_reg     <= idx_next;
        res_reg     <= res_next;
    end

endmodule

// ===== hw/rtl/isplit_checker.sv =====
// Port-level checks for the interval substep splitter, bound to the top level.
module isplit_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [isplit_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [isplit_pkg::DATA_W-1:0]    cfg_wdata,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic signed [isplit_pkg::DATA_W-1:0] requested_interval,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [isplit_pkg::DATA_W-1:0]    substep_len,
    input  logic [isplit_pkg::IDX_W-1:0]     substep_index,
    input  logic                             last,
    input  logic [isplit_pkg::DATA_W-1:0]    total_len,
    input  logic                             clamped_up,
    input  logic                             split_used,
    input  logic                             count_saturated,
    input  logic [1:0]                       error_code
);
    import isplit_pkg::*;

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(substep_len) && $stable(substep_index))
        else $error("output transaction changed while stalled");

    // Error transactions are single empty substeps
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != ERR_NONE) |->
            last && (substep_len == '0) && (substep_index == '0) && (total_len == '0))
        else $error("error transaction has wrong form");

    // A run without split has only substep zero
    a_nosplit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !split_used |-> last && (substep_index == '0))
        else $error("unsplit run has more than one substep");

    // A non-final substep belongs to a good, split run
    a_mid_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> split_used && (error_code == ERR_NONE))
        else $error("non-final substep outside a split run");

endmodule

bind interval_substep_splitter isplit_checker u_isplit_checker (.*);
